@@ design/fractional_delay_line_macros.svh @@
// Assertion macros for the fractional delay line.
// Included by the top level; needs nothing else.
`ifndef FRACTIONAL_DELAY_LINE_MACROS_SVH
`define FRACTIONAL_DELAY_LINE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define FDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fractional_delay_line: check failed");
// The consequent must hold in the cycle after the antecedent.
`define FDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fractional_delay_line: check failed");
`else
`define FDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/fdl_pkg.sv @@
// Shared constants and types for the fractional delay line.
// No dependencies.
package fdl_pkg;

    localparam int DEPTH_DEF       = 65536;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int DELAY_W    = 24;
    localparam int CFG_LEN_W  = 17;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_LEN_W-1:0] CFG_LEN_RESET = 17'd65536;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_ACTIVE_LENGTH = 1'b0
    } t_reg_index;

endpackage

@@ design/fractional_delay_line.sv @@
// Fractional delay line: circular sample store with linear interpolation on read.
// Depends on fdl_pkg and fractional_delay_line_macros.svh.
//
// The block takes one item per clock unless the output stalls, writes and reads in
// any mix, with no stall of its own. A write stores the sample at the write pointer
// and gives no result; a read returns the interpolated sample through the pipeline
// registers in the output register, one memory access per item on a store with one
// write port and two registered read ports. Entries not written since reset or since
// the last change of active_length read as zero; this is tracked by the write pointer
// and a wrap flag, so there is no clearing pass and the block is ready directly after
// reset. A write to active_length restarts the line empty.
`include "fractional_delay_line_macros.svh"

module fractional_delay_line #(
    parameter int DEPTH       = fdl_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    input  logic [fdl_pkg::DELAY_W-1:0]         i_delay,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fdl_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fdl_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fdl_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int AW  = $clog2(DEPTH);
    localparam int LW  = AW + 1;
    localparam int F   = FRAC_BITS;
    localparam int SB  = SAMPLE_BITS;
    localparam int PW  = AW + 1 + F;
    localparam int DLW = fdl_pkg::DELAY_W;
    localparam int CW  = (DLW > AW + F) ? DLW : AW + F;
    localparam int CLW = fdl_pkg::CFG_LEN_W;
    localparam int EW  = (CLW > LW) ? CLW : LW;
    localparam int DW  = fdl_pkg::APB_DATA_W;
    localparam int PRW = SB + F + 2;

    // Effective length: zero acts as one, anything above the store depth as the depth.
    function automatic logic [LW-1:0] eff_len(input logic [CLW-1:0] c);
        logic [EW-1:0] ce;
        ce = EW'(c);
        if (c == '0) begin
            eff_len = LW'(1);
        end else if (ce > EW'(DEPTH)) begin
            eff_len = LW'(DEPTH);
        end else begin
            eff_len = LW'(ce);
        end
    endfunction

    localparam logic [LW-1:0] LEN_RST    = eff_len(fdl_pkg::CFG_LEN_RESET);
    localparam logic [AW-1:0] LEN_M1_RST = AW'(LEN_RST - 1'b1);

    // Configuration and write-pointer state.
    logic [CLW-1:0] r_cfg_len;
    logic [LW-1:0]  r_len;
    logic [AW-1:0]  r_len_m1;
    logic [AW-1:0]  r_wp;
    logic           r_full;

    // Sample store.
    logic [SB-1:0]  r_mem [DEPTH];

    // Pipeline registers.
    logic                   r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    fdl_pkg::t_opcode       r_op1, r_op2;
    logic [SB-1:0]          r_smp1, r_smp2;
    logic [AW-1:0]          r_wp1, r_wp2, r_wp3;
    logic                   r_full1, r_full2, r_full3;
    logic [LW-1:0]          r_base1;
    logic [AW+F-1:0]        r_dcl1;
    logic [LW-1:0]          r_raw2;
    logic [F-1:0]           r_frac2, r_frac3, r_frac4;
    logic [AW-1:0]          r_idx0_3, r_idx1_3;
    logic [SB-1:0]          r_q0, r_q1;
    logic signed [SB-1:0]   r_s0_4, r_s0_5;
    logic signed [SB:0]     r_diff4;
    logic signed [PRW-1:0]  r_prod5;
    logic [SB-1:0]          r_out;

    // Combinational signals.
    logic                   w_cfg_wr;
    logic [LW-1:0]          n_len;
    logic                   w_en1, w_en2, w_en3, w_en4, w_en5, w_en_out;
    logic                   w_in_acc;
    logic [AW+F-1:0]        w_dmax;
    logic [CW-1:0]          w_d_ext;
    logic [AW+F-1:0]        w_d_cl;
    logic [LW-1:0]          w_base;
    logic [PW-1:0]          w_pos;
    logic [LW-1:0]          w_idx0_full, w_idx1_full;
    logic [AW-1:0]          w_idx0, w_idx1;
    logic signed [SB-1:0]   w_s0, w_s1;
    logic signed [SB:0]     w_diff;
    logic signed [PRW-1:0]  w_prod, w_prod_sh;
    logic [SB-1:0]          w_out;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (fdl_pkg::t_reg_index'(paddr[2]) == fdl_pkg::REG_ACTIVE_LENGTH);
    assign n_len    = eff_len(pwdata[CLW-1:0]);

    always_comb begin
        case (fdl_pkg::t_reg_index'(paddr[2]))
            fdl_pkg::REG_ACTIVE_LENGTH: prdata = DW'(r_cfg_len);
            default:                    prdata = '0;
        endcase
    end

    // Stall chain: a stage loads when it is empty or its content moves on.
    assign w_en_out   = !r_ov || i_out_ready;
    assign w_en5      = !r_v5 || w_en_out;
    assign w_en4      = !r_v4 || w_en5;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_ready = w_en1;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= fdl_pkg::CFG_LEN_RESET;
            r_len     <= LEN_RST;
            r_len_m1  <= LEN_M1_RST;
            r_wp      <= '0;
            r_full    <= 1'b0;
        end else if (w_cfg_wr) begin
            r_cfg_len <= pwdata[CLW-1:0];
            r_len     <= n_len;
            r_len_m1  <= AW'(n_len - 1'b1);
            r_wp      <= '0;
            r_full    <= 1'b0;
        end else if (w_in_acc && fdl_pkg::t_opcode'(i_opcode) == fdl_pkg::OP_WRITE) begin
            if (r_wp == r_len_m1) begin
                r_wp   <= '0;
                r_full <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    // Stage 0: clamp the delay and form the base position wp + length - 1.
    assign w_dmax  = {r_len_m1, {F{1'b0}}};
    assign w_d_ext = CW'(i_delay);
    assign w_d_cl  = (w_d_ext > CW'(w_dmax)) ? w_dmax : w_d_ext[AW+F-1:0];
    assign w_base  = LW'(r_wp) + LW'(r_len_m1);

    // Stage 1: fixed-point read position, never negative after the clamp.
    assign w_pos = {r_base1, {F{1'b0}}} - PW'(r_dcl1);

    // Stage 2: wrap both neighbours into the active slots.
    assign w_idx0_full = (r_raw2 > LW'(r_len_m1)) ? r_raw2 - r_len : r_raw2;
    assign w_idx1_full = (r_raw2 >= LW'(r_len_m1)) ? r_raw2 - LW'(r_len_m1)
                                                   : r_raw2 + 1'b1;
    assign w_idx0 = w_idx0_full[AW-1:0];
    assign w_idx1 = w_idx1_full[AW-1:0];

    // Writes and reads touch the store in the same stage, so order is kept.
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            if (r_v2 && r_op2 == fdl_pkg::OP_WRITE) begin
                r_mem[r_wp2] <= r_smp2;
            end
            r_q0 <= r_mem[w_idx0];
            r_q1 <= r_mem[w_idx1];
        end
    end

    // Stage 3: entries not written since the line was emptied read as zero.
    assign w_s0   = (r_full3 || r_idx0_3 < r_wp3) ? r_q0 : '0;
    assign w_s1   = (r_full3 || r_idx1_3 < r_wp3) ? r_q1 : '0;
    assign w_diff = $signed({w_s1[SB-1], w_s1}) - $signed({w_s0[SB-1], w_s0});

    // Stage 4: weight the difference by the fraction.
    assign w_prod = r_diff4 * $signed({1'b0, r_frac4});

    // Stage 5: the arithmetic shift floors; the sum stays between the neighbours.
    assign w_prod_sh = r_prod5 >>> F;
    assign w_out     = r_s0_5 + w_prod_sh[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_in_acc;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            // Writes leave the pipeline once they reach the store.
            if (w_en3) begin
                r_v3 <= r_v2 && r_op2 == fdl_pkg::OP_READ;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
            if (w_en_out) begin
                r_ov <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_op1   <= fdl_pkg::t_opcode'(i_opcode);
            r_smp1  <= i_sample_in;
            r_wp1   <= r_wp;
            r_full1 <= r_full;
            r_base1 <= w_base;
            r_dcl1  <= w_d_cl;
        end
        if (w_en2) begin
            r_op2   <= r_op1;
            r_smp2  <= r_smp1;
            r_wp2   <= r_wp1;
            r_full2 <= r_full1;
            r_raw2  <= w_pos[PW-1:F];
            r_frac2 <= w_pos[F-1:0];
        end
        if (w_en3) begin
            r_wp3    <= r_wp2;
            r_full3  <= r_full2;
            r_idx0_3 <= w_idx0;
            r_idx1_3 <= w_idx1;
            r_frac3  <= r_frac2;
        end
        if (w_en4) begin
            r_s0_4  <= w_s0;
            r_diff4 <= w_diff;
            r_frac4 <= r_frac3;
        end
        if (w_en5) begin
            r_s0_5  <= r_s0_4;
            r_prod5 <= w_prod;
        end
        if (w_en_out) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_sample_out = r_out;

    `FDL_ASSERT_IMP(a_wp_in_range, i_clk, i_rst_n, 1'b1, r_wp <= r_len_m1)
    `FDL_ASSERT_NXT(a_wp_step, i_clk, i_rst_n,
        w_in_acc && !w_cfg_wr && fdl_pkg::t_opcode'(i_opcode) == fdl_pkg::OP_WRITE,
        (r_wp == '0) ? ($past(r_wp) == $past(r_len_m1)) : (r_wp == AW'($past(r_wp) + 1'b1)))
    `FDL_ASSERT_IMP(a_idx_adjacent, i_clk, i_rst_n, r_v3, r_idx1_3 == AW'(r_idx0_3 + 1'b1) || r_idx1_3 == '0)

endmodule
